[hw/rtl/led_flash_breath_pattern_macros.svh]
// ----------------------------------------------------------------------------
// LED pattern generator assertion macros
// Concurrent assertion helpers shared by the RTL; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef LED_FLASH_BREATH_PATTERN_MACROS_SVH
`define LED_FLASH_BREATH_PATTERN_MACROS_SVH

`ifndef SYNTHESIS

// The condition holds at every clock edge outside reset.
`define LFB_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("LED pattern assertion failed");

// The consequent holds in the same cycle as the antecedent.
`define LFB_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("LED pattern assertion failed");

// The consequent holds in the cycle after the antecedent.
`define LFB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("LED pattern assertion failed");

`else

`define LFB_ASSERT_ALWAYS(label, clk, rst, cond)
`define LFB_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define LFB_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[hw/rtl/lfb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED pattern generator package
// Field widths, register and code constants, and the channel payload types.
// ----------------------------------------------------------------------------
package lfb_pkg;

  localparam int unsigned LevelW  = 7;
  localparam int unsigned PeriodW = 12;
  localparam int unsigned ModeW   = 2;
  localparam int unsigned ColorW  = 2;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 12;
  localparam int unsigned NumW    = 19;
  localparam int unsigned StepW   = 5;

  localparam logic [LevelW-1:0]  LevelFull    = 7'd100;
  localparam logic [PeriodW-1:0] PeriodReset  = 12'd50;

  localparam logic [CfgIdxW-1:0] REG_PATTERN = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_COLOR   = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_PERIOD  = 2'd2;

  localparam logic [ModeW-1:0] PAT_STEADY = 2'd0;
  localparam logic [ModeW-1:0] PAT_FLASH  = 2'd1;
  localparam logic [ModeW-1:0] PAT_BREATH = 2'd2;

  localparam logic [ColorW-1:0] COLOR_OFF    = 2'd0;
  localparam logic [ColorW-1:0] COLOR_GREEN  = 2'd1;
  localparam logic [ColorW-1:0] COLOR_ORANGE = 2'd2;
  localparam logic [ColorW-1:0] COLOR_RED    = 2'd3;

  typedef struct packed {
    logic tick;
  } tick_item_t;

  typedef struct packed {
    logic [LevelW-1:0] green_level;
    logic [LevelW-1:0] red_level;
  } level_item_t;

endpackage

[hw/rtl/lfb_stream_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED pattern generator stream channel
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface lfb_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

[hw/rtl/led_flash_breath_pattern.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED flash and breath pattern generator
// Two-color LED brightness generator advanced by one transaction per tick.
// ----------------------------------------------------------------------------
// Each tick transaction with tick set, while output is enabled, yields one
// result with the green and red brightness in percent. A write to the
// pattern, color or period register restarts the pattern and enables output;
// the steady pattern gives a single result and then stops until the next
// write. A breath tick runs through the calculate state, the 19 steps of the
// serial restoring divider and the emit state, which loads its result into
// the output register once that register is free; steady and flash skip the
// divider. The block accepts the next tick once its sequencer is idle again,
// even while a result still waits in the output register.
`include "led_flash_breath_pattern_macros.svh"

module led_flash_breath_pattern
  import lfb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  lfb_stream_if.sink         ticks,
  lfb_stream_if.source       levels,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CALC = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]         state;
  logic [ModeW-1:0]   pattern;
  logic [ColorW-1:0]  led_color;
  logic [PeriodW-1:0] period_ticks;
  logic [PeriodW-1:0] phase_count;
  logic               update_enable;

  logic [PeriodW-1:0] work_c;
  logic [PeriodW-1:0] work_p;
  logic [ModeW-1:0]   work_pat;
  logic [ColorW-1:0]  work_color;
  logic [NumW-1:0]    quot;
  logic [PeriodW-1:0] rem;
  logic [StepW-1:0]   step;

  logic               take;
  logic               start;
  logic [PeriodW-1:0] p_sat;
  logic [PeriodW-1:0] half;
  logic               past_half;
  logic [PeriodW:0]   tri_x;
  logic [NumW:0]      tri_num;
  logic [PeriodW:0]   rem_shift;
  logic               ge;
  logic [PeriodW:0]   diff;
  logic [LevelW-1:0]  lvl;
  logic [LevelW-1:0]  green_next;
  logic [LevelW-1:0]  red_next;
  logic               emit;

  assign ticks.ready = (state == ST_IDLE);
  assign take        = ticks.valid && ticks.ready;
  assign start       = take && ticks.data.tick && update_enable;
  assign p_sat       = (period_ticks == '0) ? PeriodW'(1) : period_ticks;
  assign emit        = (state == ST_EMIT) && (!levels.valid || levels.ready);

  always_comb begin
    half      = work_p >> 1;
    past_half = work_c > half;
    if (past_half) begin
      tri_x = {work_c, 1'b0} - {1'b0, work_p};
    end else begin
      tri_x = {1'b0, work_p} - {work_c, 1'b0};
    end
    tri_num = (NumW + 1)'(tri_x) * (NumW + 1)'(LevelFull);

    rem_shift = {rem, quot[NumW-1]};
    ge        = rem_shift >= {1'b0, work_p};
    diff      = rem_shift - {1'b0, work_p};

    if (quot > NumW'(LevelFull)) begin
      lvl = LevelFull;
    end else begin
      lvl = quot[LevelW-1:0];
    end
    green_next = '0;
    red_next   = '0;
    case (work_color)
      COLOR_GREEN: green_next = lvl;
      COLOR_ORANGE: begin
        green_next = lvl;
        red_next   = lvl;
      end
      COLOR_RED: red_next = lvl;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      pattern       <= PAT_STEADY;
      led_color     <= COLOR_OFF;
      period_ticks  <= PeriodReset;
      phase_count   <= '0;
      update_enable <= 1'b0;
      levels.valid  <= 1'b0;
      step          <= '0;
    end else begin
      if (emit) begin
        levels.valid <= 1'b1;
      end else if (levels.valid && levels.ready) begin
        levels.valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (start) begin
            work_c     <= phase_count;
            work_p     <= p_sat;
            work_pat   <= pattern;
            work_color <= led_color;
            if (phase_count > p_sat) begin
              phase_count <= '0;
            end else begin
              phase_count <= phase_count + PeriodW'(1);
            end
            if (pattern != PAT_FLASH && pattern != PAT_BREATH) begin
              update_enable <= 1'b0;
            end
            state <= ST_CALC;
          end
        end
        ST_CALC: begin
          rem  <= '0;
          step <= StepW'(NumW - 1);
          case (work_pat)
            PAT_FLASH: begin
              quot  <= past_half ? '0 : NumW'(LevelFull);
              state <= ST_EMIT;
            end
            PAT_BREATH: begin
              quot  <= tri_num[NumW-1:0];
              state <= ST_DIV;
            end
            default: begin
              quot  <= NumW'(LevelFull);
              state <= ST_EMIT;
            end
          endcase
        end
        ST_DIV: begin
          quot <= {quot[NumW-2:0], ge};
          rem  <= ge ? diff[PeriodW-1:0] : rem_shift[PeriodW-1:0];
          step <= step - StepW'(1);
          if (step == '0) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase

      if (cfg_we) begin
        unique case (cfg_index)
          REG_PATTERN: pattern      <= cfg_data[ModeW-1:0];
          REG_COLOR:   led_color    <= cfg_data[ColorW-1:0];
          REG_PERIOD:  period_ticks <= cfg_data[PeriodW-1:0];
          default: ;
        endcase
        if (cfg_index == REG_PATTERN || cfg_index == REG_COLOR ||
            cfg_index == REG_PERIOD) begin
          phase_count   <= '0;
          update_enable <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      levels.data.green_level <= green_next;
      levels.data.red_level   <= red_next;
    end
  end

  `LFB_ASSERT_IMPLIES(a_level_range, clk, rst, levels.valid,
    (levels.data.green_level <= LevelFull) && (levels.data.red_level <= LevelFull))
  `LFB_ASSERT_ALWAYS(a_phase_bound, clk, rst,
    ({1'b0, phase_count} <= ({1'b0, p_sat} + (PeriodW + 1)'(1))))
  `LFB_ASSERT_NEXT(a_steady_stops, clk, rst, start && !cfg_we && (pattern == PAT_STEADY), !update_enable)
  `LFB_ASSERT_NEXT(a_div_ends, clk, rst, (state == ST_DIV) && (step == '0), state == ST_EMIT)

endmodule
